>>> rtl/segment_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// segment allocator assertion macros
// shorthand for clocked assertions that are disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ALLOCATOR_UNIT_MACROS_SVH
`define SEGMENT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define SAU_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define SAU_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/sau_pkg.sv
// ----------------------------------------------------------------------------
// sau_pkg
// sizes, operation and status codes and shared types of the segment allocator
// ----------------------------------------------------------------------------
package sau_pkg;

    // sizing
    localparam int MEM_WORDS    = 1024;
    localparam int FREE_ENTRIES = 16;
    localparam int SEGMENT_IDS  = 16;
    localparam int DATA_WIDTH   = 32;

    // fixed field widths
    localparam int OP_W      = 3;
    localparam int ID_W      = 4;
    localparam int POS_W     = 10;
    localparam int LEN_W     = 11;
    localparam int STRAT_W   = 2;
    localparam int STAT_W    = 3;
    localparam int IN_DATA_W = 32;

    // derived widths
    localparam int IDX_W   = $clog2(FREE_ENTRIES);
    localparam int LINK_W  = IDX_W + 1;
    localparam int WORD_AW = $clog2(MEM_WORDS);
    localparam int SID_W   = $clog2(SEGMENT_IDS);

    // operation codes
    localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
    localparam logic [OP_W-1:0] OP_STORE  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_HOLD = 3'd1;
    localparam logic [STAT_W-1:0] ST_SMALL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STAT_W-1:0] ST_BOUNDS  = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd5;

    // fit rules
    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    // one free list entry as kept in memory
    typedef struct packed {
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic [LINK_W-1:0] link;
    } t_free_entry;

    localparam int FE_W = $bits(t_free_entry);

    // request to the free list engine
    typedef struct packed {
        logic                start;
        logic [OP_W-1:0]     op;
        logic [POS_W-1:0]    s;
        logic [LEN_W-1:0]    size;
        logic [STRAT_W-1:0]  strategy;
        logic [POS_W-1:0]    base;
        logic [LEN_W-1:0]    len;
    } t_fl_req;

    // response of the free list engine
    typedef struct packed {
        logic                done;
        logic [STAT_W-1:0]   status;
        logic                found;
        logic [POS_W-1:0]    addr;
    } t_fl_resp;

endpackage

>>> rtl/sau_ram.sv
// ----------------------------------------------------------------------------
// sau_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sau_free_list.sv
// ----------------------------------------------------------------------------
// sau_free_list
// free list engine: walks the linked list in memory one link per cycle,
// then splits, merges, links or unlinks entries for create and remove, or picks a fit
// ----------------------------------------------------------------------------
`include "segment_allocator_unit_macros.svh"

module sau_free_list (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_init,
    input  logic [sau_pkg::LEN_W-1:0] i_init_words,
    input  sau_pkg::t_fl_req          i_req,
    output sau_pkg::t_fl_resp         o_resp
);

    localparam int IDX_W  = sau_pkg::IDX_W;
    localparam int LINK_W = sau_pkg::LINK_W;
    localparam int LEN_W  = sau_pkg::LEN_W;
    localparam int POS_W  = sau_pkg::POS_W;
    localparam int SUM_W  = LEN_W + 1;
    localparam int FE_W   = sau_pkg::FE_W;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(sau_pkg::FREE_ENTRIES);

    typedef enum logic [4:0] {
        F_IDLE   = 5'b00001,
        F_ISSUE  = 5'b00010,
        F_EVAL   = 5'b00100,
        F_DECIDE = 5'b01000,
        F_WR2    = 5'b10000
    } t_fl_state;

    // control state
    t_fl_state                       r_state, n_state;
    logic [LINK_W-1:0]               r_head, n_head;
    logic [sau_pkg::FREE_ENTRIES-1:0] r_used, n_used;

    // request copy
    logic [sau_pkg::OP_W-1:0]    r_op, n_op;
    logic [POS_W-1:0]            r_s, n_s;
    logic [LEN_W-1:0]            r_size, n_size;
    logic [sau_pkg::STRAT_W-1:0] r_strategy, n_strategy;
    logic [POS_W-1:0]            r_base, n_base;
    logic [LEN_W-1:0]            r_len, n_len;

    // walk position
    logic [LINK_W-1:0]    r_cur, n_cur;
    logic [LINK_W-1:0]    r_prev, n_prev;
    logic [LINK_W-1:0]    r_n, n_n;
    sau_pkg::t_free_entry r_prev_data, n_prev_data;

    // captured entries: left neighbor or fit choice, and holder or right neighbor
    logic                 r_p_ok, n_p_ok;
    logic [IDX_W-1:0]     r_p_idx, n_p_idx;
    sau_pkg::t_free_entry r_p_data, n_p_data;
    logic                 r_nx_ok, n_nx_ok;
    logic [IDX_W-1:0]     r_nx_idx, n_nx_idx;
    sau_pkg::t_free_entry r_nx_data, n_nx_data;
    logic [LINK_W-1:0]    r_nprev, n_nprev;
    sau_pkg::t_free_entry r_nprev_data, n_nprev_data;

    // second write and result
    logic                       r_w2_en, n_w2_en;
    logic [IDX_W-1:0]           r_w2_idx, n_w2_idx;
    sau_pkg::t_free_entry       r_w2_data, n_w2_data;
    logic [sau_pkg::STAT_W-1:0] r_status, n_status;
    logic                       r_found, n_found;
    logic [POS_W-1:0]           r_addr, n_addr;

    // memory port
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    sau_pkg::t_free_entry w_wdata;
    logic [IDX_W-1:0]     w_raddr;
    logic [FE_W-1:0]      w_rd_raw;
    sau_pkg::t_free_entry w_rd;
    sau_pkg::t_free_entry w_init_data;

    // first write, decided combinationally
    logic                 w_w1_en;
    logic [IDX_W-1:0]     w_w1_idx;
    sau_pkg::t_free_entry w_w1_data;

    // walk compare terms
    logic [SUM_W-1:0] w_rd_fs, w_rd_fe, w_s, w_send, w_base, w_bend, w_h_fs, w_h_fe;
    logic             w_hold, w_fit, w_more, w_take, w_stop, w_before, w_after;

    // lowest unused entry
    logic             w_spare_ok;
    logic [IDX_W-1:0] w_spare;

    sau_ram #(
        .WIDTH (FE_W),
        .DEPTH (sau_pkg::FREE_ENTRIES)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_raw)
    );

    assign w_rd = w_rd_raw;

    // entry under the walk and the piece that holds the create start
    assign w_rd_fs  = SUM_W'(w_rd.start);
    assign w_rd_fe  = SUM_W'(w_rd.start) + SUM_W'(w_rd.len);
    assign w_s      = SUM_W'(r_s);
    assign w_send   = SUM_W'(r_s) + SUM_W'(r_size);
    assign w_base   = SUM_W'(r_base);
    assign w_bend   = SUM_W'(r_base) + SUM_W'(r_len);
    assign w_h_fs   = SUM_W'(r_nx_data.start);
    assign w_h_fe   = SUM_W'(r_nx_data.start) + SUM_W'(r_nx_data.len);
    assign w_before = w_h_fs < w_s;
    assign w_after  = w_h_fe > w_send;
    assign w_hold   = (w_rd_fs <= w_s) && (w_s <= w_rd_fe);
    assign w_fit    = w_rd.len >= r_size;
    assign w_more   = (w_rd.link < NIL) && ((32'(r_n) + 1) < sau_pkg::FREE_ENTRIES);

    // fit rule
    always_comb begin
        case (r_strategy)
            sau_pkg::STRAT_FIRST: w_take = w_fit;
            sau_pkg::STRAT_BEST:  w_take = w_fit && (!r_p_ok || (w_rd.len < r_p_data.len));
            sau_pkg::STRAT_WORST: w_take = !r_p_ok || (w_rd.len > r_p_data.len);
            default:              w_take = 1'b0;
        endcase
    end

    assign w_stop = ((r_op == sau_pkg::OP_CREATE) && w_hold) ||
                    ((r_op == sau_pkg::OP_FIND) && (r_strategy == sau_pkg::STRAT_FIRST) &&
                     w_fit) ||
                    !w_more;

    // priority encoder over the used bits
    always_comb begin
        w_spare_ok = 1'b0;
        w_spare    = '0;
        for (int i = sau_pkg::FREE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_spare_ok = 1'b1;
                w_spare    = IDX_W'(i);
            end
        end
    end

    // walk and update sequencer
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_used       = r_used;
        n_op         = r_op;
        n_s          = r_s;
        n_size       = r_size;
        n_strategy   = r_strategy;
        n_base       = r_base;
        n_len        = r_len;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_n          = r_n;
        n_prev_data  = r_prev_data;
        n_p_ok       = r_p_ok;
        n_p_idx      = r_p_idx;
        n_p_data     = r_p_data;
        n_nx_ok      = r_nx_ok;
        n_nx_idx     = r_nx_idx;
        n_nx_data    = r_nx_data;
        n_nprev      = r_nprev;
        n_nprev_data = r_nprev_data;
        n_w2_en      = r_w2_en;
        n_w2_idx     = r_w2_idx;
        n_w2_data    = r_w2_data;
        n_status     = r_status;
        n_found      = r_found;
        n_addr       = r_addr;
        w_raddr      = r_cur[IDX_W-1:0];
        w_w1_en      = 1'b0;
        w_w1_idx     = r_nx_idx;
        w_w1_data    = r_nx_data;

        unique case (r_state)
            F_IDLE: begin
                if (i_req.start) begin
                    n_op       = i_req.op;
                    n_s        = i_req.s;
                    n_size     = i_req.size;
                    n_strategy = i_req.strategy;
                    n_base     = i_req.base;
                    n_len      = i_req.len;
                    n_cur      = r_head;
                    n_prev     = NIL;
                    n_n        = '0;
                    n_p_ok     = 1'b0;
                    n_nx_ok    = 1'b0;
                    n_state    = F_ISSUE;
                end
            end
            F_ISSUE: begin
                n_state = (r_cur < NIL) ? F_EVAL : F_DECIDE;
            end
            F_EVAL: begin
                case (r_op)
                    sau_pkg::OP_CREATE: begin
                        if (w_hold) begin
                            n_nx_ok      = 1'b1;
                            n_nx_idx     = r_cur[IDX_W-1:0];
                            n_nx_data    = w_rd;
                            n_nprev      = r_prev;
                            n_nprev_data = r_prev_data;
                        end
                    end
                    sau_pkg::OP_REMOVE: begin
                        if (!r_p_ok && (w_rd_fe == w_base)) begin
                            n_p_ok   = 1'b1;
                            n_p_idx  = r_cur[IDX_W-1:0];
                            n_p_data = w_rd;
                        end
                        if (!r_nx_ok && (w_rd_fs == w_bend)) begin
                            n_nx_ok      = 1'b1;
                            n_nx_idx     = r_cur[IDX_W-1:0];
                            n_nx_data    = w_rd;
                            n_nprev      = r_prev;
                            n_nprev_data = r_prev_data;
                        end
                    end
                    sau_pkg::OP_FIND: begin
                        if (w_take) begin
                            n_p_ok   = 1'b1;
                            n_p_idx  = r_cur[IDX_W-1:0];
                            n_p_data = w_rd;
                        end
                    end
                    default: begin
                    end
                endcase
                // follow the link straight from the read data
                if (w_stop) begin
                    n_state = F_DECIDE;
                end else begin
                    w_raddr     = w_rd.link[IDX_W-1:0];
                    n_prev      = r_cur;
                    n_prev_data = w_rd;
                    n_cur       = w_rd.link;
                    n_n         = r_n + 1'b1;
                end
            end
            F_DECIDE: begin
                n_status = sau_pkg::ST_OK;
                n_found  = 1'b0;
                n_addr   = '0;
                n_w2_en  = 1'b0;
                n_state  = F_WR2;
                case (r_op)
                    sau_pkg::OP_CREATE: begin
                        if (!r_nx_ok) begin
                            n_status = sau_pkg::ST_NO_HOLD;
                        end else if (w_h_fe < w_send) begin
                            n_status = sau_pkg::ST_SMALL;
                        end else if (w_before && w_after) begin
                            // split in three: new entry after the segment
                            if (!w_spare_ok) begin
                                n_status = sau_pkg::ST_FULL;
                            end else begin
                                w_w1_en         = 1'b1;
                                w_w1_idx        = w_spare;
                                w_w1_data.start = POS_W'(w_send);
                                w_w1_data.len   = LEN_W'(w_h_fe - w_send);
                                w_w1_data.link  = r_nx_data.link;
                                n_w2_en         = 1'b1;
                                n_w2_idx        = r_nx_idx;
                                n_w2_data       = r_nx_data;
                                n_w2_data.len   = LEN_W'(w_s - w_h_fs);
                                n_w2_data.link  = LINK_W'(w_spare);
                                n_used[w_spare] = 1'b1;
                            end
                        end else if (w_before) begin
                            w_w1_en       = 1'b1;
                            w_w1_data.len = LEN_W'(w_s - w_h_fs);
                        end else if (w_after) begin
                            w_w1_en         = 1'b1;
                            w_w1_data.start = POS_W'(w_send);
                            w_w1_data.len   = LEN_W'(w_h_fe - w_send);
                        end else begin
                            // exact fit: unlink the holder
                            if (r_nprev == NIL) begin
                                n_head = r_nx_data.link;
                            end else begin
                                w_w1_en        = 1'b1;
                                w_w1_idx       = r_nprev[IDX_W-1:0];
                                w_w1_data      = r_nprev_data;
                                w_w1_data.link = r_nx_data.link;
                            end
                            n_used[r_nx_idx] = 1'b0;
                        end
                    end
                    sau_pkg::OP_REMOVE: begin
                        if (r_p_ok && r_nx_ok && (r_p_idx != r_nx_idx)) begin
                            // merge both sides into the left piece
                            w_w1_en       = 1'b1;
                            w_w1_idx      = r_p_idx;
                            w_w1_data     = r_p_data;
                            w_w1_data.len = LEN_W'(r_p_data.len + r_len + r_nx_data.len);
                            if (r_nprev == NIL) begin
                                n_head = r_nx_data.link;
                            end else if (r_nprev[IDX_W-1:0] == r_p_idx) begin
                                w_w1_data.link = r_nx_data.link;
                            end else begin
                                n_w2_en        = 1'b1;
                                n_w2_idx       = r_nprev[IDX_W-1:0];
                                n_w2_data      = r_nprev_data;
                                n_w2_data.link = r_nx_data.link;
                            end
                            n_used[r_nx_idx] = 1'b0;
                        end else if (r_p_ok) begin
                            w_w1_en       = 1'b1;
                            w_w1_idx      = r_p_idx;
                            w_w1_data     = r_p_data;
                            w_w1_data.len = LEN_W'(r_p_data.len + r_len);
                        end else if (r_nx_ok) begin
                            w_w1_en         = 1'b1;
                            w_w1_data.start = r_base;
                            w_w1_data.len   = LEN_W'(r_nx_data.len + r_len);
                        end else if (r_len != '0) begin
                            // lone piece goes to the list head
                            if (!w_spare_ok) begin
                                n_status = sau_pkg::ST_FULL;
                            end else begin
                                w_w1_en         = 1'b1;
                                w_w1_idx        = w_spare;
                                w_w1_data.start = r_base;
                                w_w1_data.len   = r_len;
                                w_w1_data.link  = r_head;
                                n_head          = LINK_W'(w_spare);
                                n_used[w_spare] = 1'b1;
                            end
                        end
                    end
                    sau_pkg::OP_FIND: begin
                        if (r_p_ok && (r_p_data.len >= r_size)) begin
                            n_found = 1'b1;
                            n_addr  = r_p_data.start;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            F_WR2: begin
                n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase

        // list reset to one piece at entry zero
        if (i_init) begin
            n_head    = '0;
            n_used    = '0;
            n_used[0] = 1'b1;
        end
    end

    // write port: init, then first write, then second write
    assign w_init_data.start = '0;
    assign w_init_data.len   = i_init_words;
    assign w_init_data.link  = NIL;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_w1_idx;
        w_wdata = w_w1_data;
        if (i_init) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = w_init_data;
        end else if (w_w1_en) begin
            w_we = 1'b1;
        end else if ((r_state == F_WR2) && r_w2_en) begin
            w_we    = 1'b1;
            w_waddr = r_w2_idx;
            w_wdata = r_w2_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_head  <= '0;
            r_used  <= sau_pkg::FREE_ENTRIES'(1);
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_used  <= n_used;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_s          <= n_s;
        r_size       <= n_size;
        r_strategy   <= n_strategy;
        r_base       <= n_base;
        r_len        <= n_len;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_n          <= n_n;
        r_prev_data  <= n_prev_data;
        r_p_ok       <= n_p_ok;
        r_p_idx      <= n_p_idx;
        r_p_data     <= n_p_data;
        r_nx_ok      <= n_nx_ok;
        r_nx_idx     <= n_nx_idx;
        r_nx_data    <= n_nx_data;
        r_nprev      <= n_nprev;
        r_nprev_data <= n_nprev_data;
        r_w2_en      <= n_w2_en;
        r_w2_idx     <= n_w2_idx;
        r_w2_data    <= n_w2_data;
        r_status     <= n_status;
        r_found      <= n_found;
        r_addr       <= n_addr;
    end

    assign o_resp.done   = (r_state == F_WR2);
    assign o_resp.status = r_status;
    assign o_resp.found  = r_found;
    assign o_resp.addr   = r_addr;

    // checks
    `SAU_IMPLY(a_head_used, r_head < NIL, r_used[r_head[IDX_W-1:0]], "list head is unused")
    `SAU_NEXT(a_done_single, o_resp.done, !o_resp.done, "engine done held longer than a cycle")

endmodule

>>> rtl/segment_allocator_unit.sv
// ----------------------------------------------------------------------------
// segment_allocator_unit
// segmented word memory with an ordered free list and a table of named
// segments: create, remove, find fit, store and load
// ----------------------------------------------------------------------------
// create, remove, find fit: n free entries walked (up to 16), one link per
//   cycle out of the free list memory
// store writes the word memory when taken, load waits for the registered read
// one item in flight; the next is taken while a result waits at the output
// after reset a clearing pass zeroes every word of the word memory with no
//   item accepted; configuration writes are taken during it
// ----------------------------------------------------------------------------
`include "segment_allocator_unit_macros.svh"

module segment_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sau_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sau_pkg::OP_W-1:0]      i_operation,
    input  logic [sau_pkg::ID_W-1:0]      i_segment_id,
    input  logic [sau_pkg::POS_W-1:0]     i_seg_start,
    input  logic [sau_pkg::LEN_W-1:0]     i_seg_size,
    input  logic [sau_pkg::STRAT_W-1:0]   i_strategy,
    input  logic [sau_pkg::POS_W-1:0]     i_position,
    input  logic [sau_pkg::IN_DATA_W-1:0] i_write_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sau_pkg::STAT_W-1:0]    o_status,
    output logic                          o_found,
    output logic [sau_pkg::POS_W-1:0]     o_address,
    output logic [sau_pkg::IN_DATA_W-1:0] o_read_data
);

    localparam int SID_W   = sau_pkg::SID_W;
    localparam int LEN_W   = sau_pkg::LEN_W;
    localparam int POS_W   = sau_pkg::POS_W;
    localparam int WORD_AW = sau_pkg::WORD_AW;
    localparam int DW      = sau_pkg::DATA_WIDTH;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_FREE  = 5'b00100,
        S_LOAD  = 5'b01000,
        S_DONE  = 5'b10000
    } t_top_state;

    // control state
    t_top_state                      r_state, n_state;
    logic [WORD_AW-1:0]              r_clr, n_clr;
    logic                            r_out_valid, n_out_valid;
    logic [LEN_W-1:0]                r_mem_words, n_mem_words;
    logic [sau_pkg::SEGMENT_IDS-1:0] r_seg_valid, n_seg_valid;

    // segment table
    logic [POS_W-1:0] r_seg_base [sau_pkg::SEGMENT_IDS];
    logic [POS_W-1:0] n_seg_base [sau_pkg::SEGMENT_IDS];
    logic [LEN_W-1:0] r_seg_len  [sau_pkg::SEGMENT_IDS];
    logic [LEN_W-1:0] n_seg_len  [sau_pkg::SEGMENT_IDS];

    // item in flight and pending result
    logic [sau_pkg::OP_W-1:0]      r_op, n_op;
    logic [SID_W-1:0]              r_id, n_id;
    logic [POS_W-1:0]              r_s, n_s;
    logic [LEN_W-1:0]              r_size, n_size;
    logic [sau_pkg::STAT_W-1:0]    r_res_status, n_res_status;
    logic                          r_res_found, n_res_found;
    logic [POS_W-1:0]              r_res_addr, n_res_addr;
    logic [sau_pkg::IN_DATA_W-1:0] r_res_data, n_res_data;

    // output register
    logic [sau_pkg::STAT_W-1:0]    r_out_status, n_out_status;
    logic                          r_out_found, n_out_found;
    logic [POS_W-1:0]              r_out_addr, n_out_addr;
    logic [sau_pkg::IN_DATA_W-1:0] r_out_data, n_out_data;

    // decode and checks
    logic             w_in_fire, w_cfg_fire, w_id_bad, w_oob;
    logic [SID_W-1:0] w_sid;
    logic [LEN_W-1:0] w_sum, w_cfg_words;

    // word memory port
    logic               w_word_we;
    logic [WORD_AW-1:0] w_word_waddr, w_word_raddr, w_abs;
    logic [DW-1:0]      w_word_wdata, w_word_rdata;

    // free list engine
    sau_pkg::t_fl_req  w_req;
    sau_pkg::t_fl_resp w_resp;
    logic              w_init;
    logic [LEN_W-1:0]  w_init_words;

    // a pending config transfer takes precedence over a new item
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLEAR);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;

    // request decode
    assign w_sid    = SID_W'(i_segment_id);
    assign w_id_bad = (i_operation <= sau_pkg::OP_LOAD) && (i_operation != sau_pkg::OP_FIND) &&
                      (32'(i_segment_id) >= sau_pkg::SEGMENT_IDS);
    assign w_sum    = LEN_W'(i_position) + LEN_W'(r_seg_base[w_sid]);
    assign w_oob    = (LEN_W'(i_position) >= r_seg_len[w_sid]) ||
                      (32'(w_sum) >= sau_pkg::MEM_WORDS);
    assign w_abs    = WORD_AW'(w_sum);

    // words in use, clamped
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_words = LEN_W'(1);
        end else if (32'(i_cfg_data) > sau_pkg::MEM_WORDS) begin
            w_cfg_words = LEN_W'(sau_pkg::MEM_WORDS);
        end else begin
            w_cfg_words = i_cfg_data;
        end
    end

    // free list init during the clearing pass and on a config transfer
    assign w_init       = (r_state == S_CLEAR) || w_cfg_fire;
    assign w_init_words = w_cfg_fire ? w_cfg_words : r_mem_words;

    sau_free_list u_free_list (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (w_init),
        .i_init_words (w_init_words),
        .i_req        (w_req),
        .o_resp       (w_resp)
    );

    sau_ram #(
        .WIDTH (DW),
        .DEPTH (sau_pkg::MEM_WORDS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_word_we),
        .i_waddr (w_word_waddr),
        .i_wdata (w_word_wdata),
        .i_raddr (w_word_raddr),
        .o_rdata (w_word_rdata)
    );

    assign w_word_raddr = w_abs;

    // dispatch, completion and output
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid;
        n_mem_words  = r_mem_words;
        n_seg_valid  = r_seg_valid;
        n_seg_base   = r_seg_base;
        n_seg_len    = r_seg_len;
        n_op         = r_op;
        n_id         = r_id;
        n_s          = r_s;
        n_size       = r_size;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_addr   = r_res_addr;
        n_res_data   = r_res_data;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_addr   = r_out_addr;
        n_out_data   = r_out_data;
        w_word_we    = 1'b0;
        w_word_waddr = w_abs;
        w_word_wdata = DW'(i_write_data);
        w_req.start    = 1'b0;
        w_req.op       = i_operation;
        w_req.s        = i_seg_start;
        w_req.size     = i_seg_size;
        w_req.strategy = i_strategy;
        w_req.base     = r_seg_base[w_sid];
        w_req.len      = r_seg_len[w_sid];

        // output transfer
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_word_we    = 1'b1;
                w_word_waddr = r_clr;
                w_word_wdata = '0;
                n_clr        = r_clr + 1'b1;
                if (r_clr == WORD_AW'(sau_pkg::MEM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_fire) begin
                    n_op         = i_operation;
                    n_id         = w_sid;
                    n_s          = i_seg_start;
                    n_size       = i_seg_size;
                    n_res_status = sau_pkg::ST_OK;
                    n_res_found  = 1'b0;
                    n_res_addr   = '0;
                    n_res_data   = '0;
                    n_state      = S_DONE;
                    if (w_id_bad) begin
                        n_res_status = sau_pkg::ST_UNKNOWN;
                    end else begin
                        case (i_operation)
                            sau_pkg::OP_CREATE, sau_pkg::OP_FIND: begin
                                w_req.start = 1'b1;
                                n_state     = S_FREE;
                            end
                            sau_pkg::OP_REMOVE: begin
                                if (!r_seg_valid[w_sid]) begin
                                    n_res_status = sau_pkg::ST_UNKNOWN;
                                end else begin
                                    w_req.start = 1'b1;
                                    n_state     = S_FREE;
                                end
                            end
                            sau_pkg::OP_STORE, sau_pkg::OP_LOAD: begin
                                if (!r_seg_valid[w_sid]) begin
                                    n_res_status = sau_pkg::ST_UNKNOWN;
                                end else if (w_oob) begin
                                    n_res_status = sau_pkg::ST_BOUNDS;
                                end else begin
                                    n_res_addr = POS_W'(w_sum);
                                    if (i_operation == sau_pkg::OP_STORE) begin
                                        w_word_we = 1'b1;
                                    end else begin
                                        n_state = S_LOAD;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_FREE: begin
                if (w_resp.done) begin
                    n_res_status = w_resp.status;
                    n_res_found  = w_resp.found;
                    n_res_addr   = w_resp.addr;
                    if (w_resp.status == sau_pkg::ST_OK) begin
                        if (r_op == sau_pkg::OP_CREATE) begin
                            n_seg_valid[r_id] = 1'b1;
                            n_seg_base[r_id]  = r_s;
                            n_seg_len[r_id]   = r_size;
                            n_res_addr        = r_s;
                        end else if (r_op == sau_pkg::OP_REMOVE) begin
                            n_seg_valid[r_id] = 1'b0;
                        end
                    end
                    n_state = S_DONE;
                end
            end
            S_LOAD: begin
                n_res_data = sau_pkg::IN_DATA_W'(w_word_rdata);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                    n_out_addr   = r_res_addr;
                    n_out_data   = r_res_data;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration transfer
        if (w_cfg_fire) begin
            n_mem_words = w_cfg_words;
            n_seg_valid = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_mem_words <= LEN_W'(sau_pkg::MEM_WORDS);
            r_seg_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_mem_words <= n_mem_words;
            r_seg_valid <= n_seg_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_seg_base   <= n_seg_base;
        r_seg_len    <= n_seg_len;
        r_op         <= n_op;
        r_id         <= n_id;
        r_s          <= n_s;
        r_size       <= n_size;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_addr   <= n_res_addr;
        r_res_data   <= n_res_data;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_addr   <= n_out_addr;
        r_out_data   <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_address   = r_out_addr;
    assign o_read_data = r_out_data;

    // checks
    `SAU_IMPLY(a_done_in_free, w_resp.done, r_state == S_FREE, "engine done outside a list operation")
    `SAU_IMPLY(a_found_ok, o_out_valid && o_found, o_status == sau_pkg::ST_OK, "found with bad status")

endmodule

>>> bench/tb_segment_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_segment_allocator_unit
// self-checking bench for the segment allocator: a directed stimulus table,
// then random create, remove, find, store, load and unknown-op traffic over several
// memory sizes, each result compared with its typed row or a cycle-free allocator predictor
// ----------------------------------------------------------------------------
module tb_segment_allocator_unit;
    import sau_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEMS_PHASE  = 260;
    localparam int SETTLE       = 40;
    localparam int NIL          = FREE_ENTRIES;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [ID_W-1:0]      id;
        logic [POS_W-1:0]     start;
        logic [LEN_W-1:0]     size;
        logic [STRAT_W-1:0]   strat;
        logic [POS_W-1:0]     pos;
        logic [IN_DATA_W-1:0] data;
    } alloc_req_t;

    typedef struct {
        logic [STAT_W-1:0]    status;
        logic                 found;
        logic [POS_W-1:0]     address;
        logic [IN_DATA_W-1:0] read_data;
    } alloc_res_t;

    typedef struct {
        alloc_req_t req;
        bit         typed;
        alloc_res_t res;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LEN_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_operation = '0;
    logic [ID_W-1:0]      i_segment_id = '0;
    logic [POS_W-1:0]     i_seg_start = '0;
    logic [LEN_W-1:0]     i_seg_size = '0;
    logic [STRAT_W-1:0]   i_strategy = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic [IN_DATA_W-1:0] i_write_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic                 o_found;
    logic [POS_W-1:0]     o_address;
    logic [IN_DATA_W-1:0] o_read_data;

    segment_allocator_unit dut (.*);

    // clock and run limit
    always #10 i_clk = ~i_clk;

    int cycles = 0;
    int errors = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // allocator predictor state
    int                   words_in_use;
    int                   fr_start [FREE_ENTRIES];
    int                   fr_len   [FREE_ENTRIES];
    int                   fr_link  [FREE_ENTRIES];
    bit                   fr_used  [FREE_ENTRIES];
    int                   fr_head;
    bit                   sg_live  [SEGMENT_IDS];
    int                   sg_base  [SEGMENT_IDS];
    int                   sg_len   [SEGMENT_IDS];
    logic [IN_DATA_W-1:0] words    [MEM_WORDS];
    alloc_res_t           pending_results[$];
    bit                   use_typed;
    alloc_res_t           typed_res;
    // typed expectations queued in offer order, one per item
    bit                   typed_flags[$];
    alloc_res_t           typed_vals[$];

    function automatic void rebuild_free_list();
        for (int i = 0; i < FREE_ENTRIES; i++) begin
            fr_used[i] = 0; fr_start[i] = 0; fr_len[i] = 0; fr_link[i] = NIL;
        end
        fr_used[0] = 1;
        fr_len[0] = words_in_use;
        fr_head = 0;
        for (int i = 0; i < SEGMENT_IDS; i++) sg_live[i] = 0;
    endfunction

    function automatic void set_words(logic [LEN_W-1:0] v);
        int w;
        w = v;
        if (w < 1) w = 1;
        if (w > MEM_WORDS) w = MEM_WORDS;
        words_in_use = w;
        rebuild_free_list();
    endfunction

    function automatic int unused_entry();
        for (int i = 0; i < FREE_ENTRIES; i++) if (!fr_used[i]) return i;
        return NIL;
    endfunction

    function automatic void drop_entry(int prev, int e);
        if (prev == NIL) fr_head = fr_link[e];
        else fr_link[prev] = fr_link[e];
        fr_used[e] = 0;
        fr_link[e] = NIL;
    endfunction

    function automatic logic [STAT_W-1:0] carve(int id, int s, int size);
        int cur, prev, n, fs, fe, k;
        bit pre, post;
        cur = fr_head; prev = NIL; n = 0;
        while (cur < FREE_ENTRIES && n < FREE_ENTRIES) begin
            fs = fr_start[cur];
            fe = fs + fr_len[cur];
            if (fs <= s && s <= fe) begin
                if (fe < s + size) return ST_SMALL;
                pre = fs < s;
                post = fe > s + size;
                if (pre && post) begin
                    k = unused_entry();
                    if (k == NIL) return ST_FULL;
                    fr_used[k] = 1;
                    fr_start[k] = s + size;
                    fr_len[k] = fe - s - size;
                    fr_link[k] = fr_link[cur];
                    fr_link[cur] = k;
                    fr_len[cur] = s - fs;
                end else if (pre) begin
                    fr_len[cur] = s - fs;
                end else if (post) begin
                    fr_start[cur] = s + size;
                    fr_len[cur] = fe - s - size;
                end else begin
                    drop_entry(prev, cur);
                end
                sg_live[id] = 1; sg_base[id] = s; sg_len[id] = size;
                return ST_OK;
            end
            prev = cur;
            cur = fr_link[cur];
            n++;
        end
        return ST_NO_HOLD;
    endfunction

    function automatic logic [STAT_W-1:0] give_back(int id);
        int b, l, p, nx, nprev, prev, cur, n, k;
        b = sg_base[id]; l = sg_len[id];
        p = NIL; nx = NIL; nprev = NIL; prev = NIL; cur = fr_head; n = 0;
        while (cur < FREE_ENTRIES && n < FREE_ENTRIES) begin
            if (p == NIL && fr_start[cur] + fr_len[cur] == b) p = cur;
            if (nx == NIL && fr_start[cur] == b + l) begin
                nx = cur; nprev = prev;
            end
            prev = cur;
            cur = fr_link[cur];
            n++;
        end
        if (p != NIL && nx != NIL && nx != p) begin
            fr_len[p] += l + fr_len[nx];
            drop_entry(nprev, nx);
        end else if (p != NIL) begin
            fr_len[p] += l;
        end else if (nx != NIL) begin
            fr_start[nx] = b;
            fr_len[nx] += l;
        end else if (l != 0) begin
            k = unused_entry();
            if (k == NIL) return ST_FULL;
            fr_used[k] = 1; fr_start[k] = b; fr_len[k] = l;
            fr_link[k] = fr_head;
            fr_head = k;
        end
        sg_live[id] = 0;
        return ST_OK;
    endfunction

    function automatic bit fit_search(int size, logic [STRAT_W-1:0] strat, output int addr);
        int cur, n, pick, l;
        cur = fr_head; n = 0; pick = NIL; addr = 0;
        while (cur < FREE_ENTRIES && n < FREE_ENTRIES) begin
            l = fr_len[cur];
            if (strat == STRAT_FIRST) begin
                if (l >= size) begin
                    pick = cur;
                    break;
                end
            end else if (strat == STRAT_BEST) begin
                if (l >= size && (pick == NIL || l < fr_len[pick])) pick = cur;
            end else if (strat == STRAT_WORST) begin
                if (pick == NIL || l > fr_len[pick]) pick = cur;
            end
            cur = fr_link[cur];
            n++;
        end
        if (pick == NIL || fr_len[pick] < size) return 0;
        addr = fr_start[pick];
        return 1;
    endfunction

    function automatic alloc_res_t predict(alloc_req_t r);
        alloc_res_t o;
        int a, id;
        o = '{default: '0};
        id = r.id;
        a = 0;
        case (r.op)
            OP_CREATE: begin
                o.status = carve(id, r.start, r.size);
                if (o.status == ST_OK) o.address = r.start;
            end
            OP_REMOVE: o.status = sg_live[id] ? give_back(id) : ST_UNKNOWN;
            OP_FIND: begin
                o.found = fit_search(r.size, r.strat, a);
                o.address = a;
            end
            OP_STORE, OP_LOAD: begin
                if (!sg_live[id]) begin
                    o.status = ST_UNKNOWN;
                end else if (r.pos >= sg_len[id] || sg_base[id] + r.pos >= MEM_WORDS) begin
                    o.status = ST_BOUNDS;
                end else begin
                    a = sg_base[id] + r.pos;
                    o.address = a;
                    if (r.op == OP_STORE) words[a] = r.data;
                    else o.read_data = words[a];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // transfer monitor: check results, predict on accepted items and writes
    always @(posedge i_clk) begin
        alloc_res_t e;
        alloc_req_t r;
        bit         tf;
        alloc_res_t tv;
        if (o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_found !== e.found) begin
                    $error("found exp %0d got %0d", e.found, o_found); errors++;
                end
                if (o_address !== e.address) begin
                    $error("address exp %0d got %0d", e.address, o_address); errors++;
                end
                if (o_read_data !== e.read_data) begin
                    $error("read_data exp %h got %h", e.read_data, o_read_data); errors++;
                end
            end
        end
        if (i_in_valid && o_in_ready) begin
            r = '{i_operation, i_segment_id, i_seg_start, i_seg_size, i_strategy,
                  i_position, i_write_data};
            e = predict(r);
            tf = 0;
            tv = '{default: '0};
            if (typed_flags.size() != 0) begin
                tf = typed_flags.pop_front();
                tv = typed_vals.pop_front();
            end
            pending_results.push_back(tf ? tv : e);
        end
        if (i_cfg_valid && o_cfg_ready) set_words(i_cfg_data);
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    bit hold_request = 0;
    initial begin
        int mode, span;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_request) begin
                    hold_request = 0;
                    i_out_ready <= 1'b0;
                    repeat (300) @(posedge i_clk);
                end
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= $urandom_range(0, 1);
                    default: i_out_ready <= (cycles % 4) != 0;
                endcase
            end
        end
    end

    // sender
    int burst_left = 0;

    task automatic offer(alloc_req_t r);
        int gap;
        typed_flags.push_back(use_typed);
        typed_vals.push_back(typed_res);
        i_in_valid   <= 1'b1;
        i_operation  <= r.op;
        i_segment_id <= r.id;
        i_seg_start  <= r.start;
        i_seg_size   <= r.size;
        i_strategy   <= r.strat;
        i_position   <= r.pos;
        i_write_data <= r.data;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 25);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_words(logic [LEN_W-1:0] v);
        i_in_valid <= 1'b0;
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_id(bit want_live);
        int id;
        id = $urandom_range(0, SEGMENT_IDS - 1);
        if ($urandom_range(0, 9) < 8)
            for (int t = 0; t < 16; t++) begin
                if (sg_live[id] == want_live) break;
                id = $urandom_range(0, SEGMENT_IDS - 1);
            end
        return id;
    endfunction

    function automatic alloc_req_t random_item();
        alloc_req_t r;
        int sel, e, room;
        r.op = OP_CREATE;
        r.id = $urandom; r.start = $urandom; r.size = $urandom; r.strat = $urandom;
        r.pos = $urandom; r.data = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            r.id = pick_id(0);
            if ($urandom_range(0, 9) < 8) begin
                e = $urandom_range(0, FREE_ENTRIES - 1);
                for (int t = 0; t < 32 && !fr_used[e]; t++)
                    e = $urandom_range(0, FREE_ENTRIES - 1);
                if (fr_used[e]) begin
                    r.start = fr_start[e] + $urandom_range(0, fr_len[e]);
                    room = fr_start[e] + fr_len[e] - r.start;
                    r.size = ($urandom_range(0, 7) == 0) ? room
                           : $urandom_range(0, room < 48 ? room : 48);
                end
            end
        end else if (sel < 45) begin
            r.op = OP_REMOVE;
            r.id = pick_id(1);
        end else if (sel < 60) begin
            r.op = OP_FIND;
            if ($urandom_range(0, 4) != 0) r.size = $urandom_range(0, 80);
        end else if (sel < 95) begin
            r.op = $urandom_range(0, 1) ? OP_STORE : OP_LOAD;
            r.id = pick_id(1);
            if (sg_live[r.id] && sg_len[r.id] > 0 && $urandom_range(0, 9) < 8)
                r.pos = $urandom_range(0, sg_len[r.id] - 1);
        end else begin
            r.op = $urandom_range(5, 7);
        end
        return r;
    endfunction

    // directed rows; typed results only where they are plain
    stim_row_t dir_rows[$] = '{
        '{'{OP_LOAD,   0,    0,    0, STRAT_FIRST,   0, 0}, 1, '{ST_UNKNOWN, 0, 0, 0}},
        '{'{OP_FIND,   0,    0, 1024, STRAT_FIRST,   0, 0}, 1, '{ST_OK, 1, 0, 0}},
        '{'{OP_FIND,   0,    0, 1025, STRAT_BEST,    0, 0}, 1, '{ST_OK, 0, 0, 0}},
        '{'{OP_CREATE, 0, 1023, 2047, STRAT_FIRST,   0, 0}, 1, '{ST_SMALL, 0, 0, 0}},
        '{'{OP_CREATE, 1,    0,  100, STRAT_FIRST,   0, 0}, 1, '{ST_OK, 0, 0, 0}},
        '{'{OP_STORE,  1,    0,    0, STRAT_FIRST,  99, 32'hFFFF_FFFF}, 1, '{ST_OK, 0, 99, 0}},
        '{'{OP_LOAD,   1,    0,    0, STRAT_FIRST,  99, 0}, 1, '{ST_OK, 0, 99, 32'hFFFF_FFFF}},
        '{'{OP_LOAD,   1,    0,    0, STRAT_FIRST,   5, 0}, 1, '{ST_OK, 0, 5, 0}},
        '{'{OP_LOAD,   1,    0,    0, STRAT_FIRST, 100, 0}, 1, '{ST_BOUNDS, 0, 0, 0}},
        '{'{OP_STORE,  1,    0,    0, STRAT_FIRST, 1023, 0}, 1, '{ST_BOUNDS, 0, 0, 0}},
        '{'{OP_CREATE, 2,  200,   50, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{OP_CREATE, 3, 1023,    1, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{OP_CREATE, 4,  120,    0, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{OP_CREATE, 15, 500,   20, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{OP_FIND,   0,    0,   10, STRAT_WORST,   0, 0}, 0, '{default: '0}},
        '{'{OP_FIND,   0,    0,   10, STRAT_BEST,    0, 0}, 0, '{default: '0}},
        '{'{OP_FIND,   0,    0,   10, 2'd3,          0, 0}, 1, '{ST_OK, 0, 0, 0}},
        '{'{OP_CREATE, 5, 1000,  100, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{OP_CREATE, 1,  300,   10, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{OP_REMOVE, 2,    0,    0, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{OP_REMOVE, 2,    0,    0, STRAT_FIRST,   0, 0}, 1, '{ST_UNKNOWN, 0, 0, 0}},
        '{'{OP_REMOVE, 4,    0,    0, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{OP_REMOVE, 15,   0,    0, STRAT_FIRST,   0, 0}, 0, '{default: '0}},
        '{'{3'd5,      7,  511, 2047, 2'd3,       1023, 32'h5A5A_A5A5}, 1, '{ST_OK, 0, 0, 0}},
        '{'{3'd7,      0,    0,    0, STRAT_FIRST,   0, 0}, 1, '{ST_OK, 0, 0, 0}}
    };

    logic [LEN_W-1:0] word_settings[] = '{11'd0, 11'd2047, 11'd37, 11'd16, 11'd500, 11'd1024};

    initial begin
        words_in_use = MEM_WORDS;
        rebuild_free_list();
        for (int i = 0; i < SEGMENT_IDS; i++) begin
            sg_base[i] = 0; sg_len[i] = 0;
        end
        for (int i = 0; i < MEM_WORDS; i++) words[i] = '0;
        use_typed = 0;
        typed_res = '{default: '0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_rows[i]) begin
            use_typed = dir_rows[i].typed;
            typed_res = dir_rows[i].res;
            burst_left = 1;
            offer(dir_rows[i].req);
        end
        i_in_valid <= 1'b0;
        drain();
        use_typed = 0;

        // random phases across memory sizes
        for (int ph = 0; ph <= word_settings.size(); ph++) begin
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if (ph == 1 && n == 100) hold_request = 1;
                offer(random_item());
            end
            if (ph < word_settings.size()) write_words(word_settings[ph]);
        end

        i_in_valid <= 1'b0;
        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
